// ----- hw/rtl/dpcc_pkg.sv -----
// Shared types, register codes and constants of the depth patch continuity classifier.
`default_nettype none

package dpcc_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 2'd2;

  // Register widths and reset values.
  localparam int CFG_SIZE_W = 12;
  localparam int THRESH_W   = 24;

  localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RST    = 12'd2048;
  localparam logic [CFG_SIZE_W-1:0] FRAME_HEIGHT_RST   = 12'd2048;
  localparam logic [THRESH_W-1:0]   LINE_THRESHOLD_RST = 24'd410;

  // Image geometry limits.
  localparam int MIN_SIZE     = 4;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int ROW_W        = 11;

  // Result field widths.
  localparam int CELL_W = 10;
  localparam int CONT_W = 8;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_DEPTH_BITS = 24;

  // Entries of each decoupling queue.
  localparam int QUEUE_DEPTH = 2;

  // How the four taps of one window axis are clamped to the image edge.
  typedef enum logic [1:0] {
    CLAMP_NONE,
    CLAMP_LOW,
    CLAMP_HIGH
  } clamp_e;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              frame_last;
  } cell_meta_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              surface;
    logic [CONT_W-1:0] continuity;
    logic              frame_last;
  } result_t;

  // Maps patch tap k (0..3) to a history column or row under an edge clamp.
  function automatic logic [1:0] clamp_tap(input clamp_e mode, input logic [1:0] k);
    logic [1:0] tap;
    unique case (mode)
      CLAMP_LOW:  tap = (k == 2'd0) ? 2'd1 : k;
      CLAMP_HIGH: tap = (k == 2'd3) ? 2'd3 : k + 2'd1;
      default:    tap = k;
    endcase
    return tap;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/depth_patch_continuity_classifier.sv -----
// Top level of the depth patch continuity classifier.
`default_nettype none

// The classifier takes one depth sample per clock in raster order and, for
// every 2x2 cell of the image, reports eight continuity flags and a surface
// bit tested over the 4x4 neighborhood of the cell, clamped at the image
// edge. It accepts one sample per cycle with no gaps of its own; the rate is
// set by the three line stores, each of which does one read at the sample's
// column per transfer, and one of which also takes the write. A cell's result
// is registered in the line store read, then in the patch queue and then in
// the result queue, after the sample that completes its neighborhood.
// The front end (counters, line stores, window) and the back end (line tests)
// are parted by a two-entry patch queue, and results wait in a two-entry
// queue, so input transfers continue while a result is not popped until both
// queues fill. The line stores start undefined and need no clearing pass:
// the edge clamp never selects a column or row that was not written in the
// current frame. Frame width, frame height and line threshold are written
// through the configuration port while the block is idle; sizes are forced
// even, at least four, and at most MAX_WIDTH columns or 2048 rows.
module depth_patch_continuity_classifier #(
  parameter int MAX_WIDTH  = dpcc_pkg::DEF_MAX_WIDTH,
  parameter int DEPTH_BITS = dpcc_pkg::DEF_DEPTH_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [dpcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dpcc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Sample input.
  input  logic                               push,
  output logic                               full,
  input  logic signed [DEPTH_BITS-1:0]       depth_value_i,
  input  logic                               depth_infinite_i,
  // Result output.
  output logic                               empty,
  input  logic                               pop,
  output logic [dpcc_pkg::CELL_W-1:0]        cell_x_o,
  output logic [dpcc_pkg::CELL_W-1:0]        cell_y_o,
  output logic                               surface_o,
  output logic [dpcc_pkg::CONT_W-1:0]        continuity_o,
  output logic                               frame_last_o
);

  import dpcc_pkg::*;

  localparam int SW     = DEPTH_BITS + 1;
  localparam int PatchW = 16 * SW;
  localparam int QW     = $bits(cell_meta_t) + PatchW;

  logic [CFG_SIZE_W-1:0] frame_width_q, frame_height_q;
  logic [THRESH_W-1:0]   line_threshold_q;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= FRAME_WIDTH_RST;
      frame_height_q   <= FRAME_HEIGHT_RST;
      line_threshold_q <= LINE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:    frame_width_q    <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data_i[CFG_SIZE_W-1:0];
        REG_LINE_THRESHOLD: line_threshold_q <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end to patch queue.
  logic                         pat_push, pat_full, pat_pop, pat_empty;
  cell_meta_t                   front_meta, back_meta;
  logic [3:0][3:0][SW-1:0]      front_patch, back_patch;
  logic [QW-1:0]                pat_rdata;

  dpcc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_width_i    (frame_width_q),
    .frame_height_i   (frame_height_q),
    .push_i           (push),
    .full_o           (full),
    .depth_value_i    (depth_value_i),
    .depth_infinite_i (depth_infinite_i),
    .pat_full_i       (pat_full),
    .pat_push_o       (pat_push),
    .pat_meta_o       (front_meta),
    .patch_o          (front_patch)
  );

  dpcc_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_pat_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pat_push),
    .wdata_i ({front_meta, front_patch}),
    .full_o  (pat_full),
    .pop_i   (pat_pop),
    .rdata_o (pat_rdata),
    .empty_o (pat_empty)
  );

  assign back_meta  = pat_rdata[QW-1:PatchW];
  assign back_patch = pat_rdata[PatchW-1:0];

  // Back end: tests the queued patch and moves it on when the result queue has room.
  result_t back_result, out_result;
  logic    res_push, res_full;

  dpcc_back #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .patch_i     (back_patch),
    .meta_i      (back_meta),
    .threshold_i (line_threshold_q),
    .result_o    (back_result)
  );

  assign res_push = !pat_empty && !res_full;
  assign pat_pop  = res_push;

  dpcc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_result),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_result),
    .empty_o (empty)
  );

  assign cell_x_o     = out_result.cell_x;
  assign cell_y_o     = out_result.cell_y;
  assign surface_o    = out_result.surface;
  assign continuity_o = out_result.continuity;
  assign frame_last_o = out_result.frame_last;

  // The front end never offers a patch to a full queue, since it stalls instead.
  a_pat_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_push |-> !pat_full)
    else $error("patch queue written while full");

  // A result written into the result queue is visible on the next cycle.
  a_res_visible : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !empty)
    else $error("result queue empty after a write");

  // Patches leave the queue only toward a result queue with room.
  a_res_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_pop |-> !res_full && !pat_empty)
    else $error("patch popped without a result slot");

endmodule

`default_nettype wire

// ----- hw/rtl/dpcc_fifo.sv -----
// Small register queue used between the classifier stages.
`default_nettype none

module dpcc_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dpcc_front.sv -----
// Front end: raster counters, line stores, column window and patch assembly.
`default_nettype none

module dpcc_front #(
  parameter int MAX_WIDTH  = dpcc_pkg::DEF_MAX_WIDTH,
  parameter int DEPTH_BITS = dpcc_pkg::DEF_DEPTH_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [dpcc_pkg::CFG_SIZE_W-1:0]      frame_width_i,
  input  logic [dpcc_pkg::CFG_SIZE_W-1:0]      frame_height_i,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic signed [DEPTH_BITS-1:0]         depth_value_i,
  input  logic                                 depth_infinite_i,
  input  logic                                 pat_full_i,
  output logic                                 pat_push_o,
  output dpcc_pkg::cell_meta_t                 pat_meta_o,
  output logic [3:0][3:0][DEPTH_BITS:0]        patch_o
);

  import dpcc_pkg::*;

  localparam int SW  = DEPTH_BITS + 1;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int SzW = ($clog2(MAX_WIDTH + 1) > CFG_SIZE_W) ? $clog2(MAX_WIDTH + 1) : CFG_SIZE_W;
  localparam int HW  = CFG_SIZE_W;

  // Raster position of the next sample.
  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       mod_q, mod_d;

  logic [SzW-1:0] w_even, w_eff, colx, c0;
  logic [HW-1:0]  h_even, h_eff, rowx, r0;
  logic           col_last, row_last, col_emit, row_emit, col_wrap, row_wrap;
  clamp_e         xmode, ymode;
  logic           accept;
  logic [SW-1:0]  cur;

  // Stage one: sample whose line store reads are in flight.
  logic             s1_valid_q, s1_emit_q, s1_fire;
  logic [SW-1:0]    s1_cur_q;
  logic [1:0]       s1_mod_q;
  cell_meta_t       s1_meta_q, meta_d;
  clamp_e           s1_xmode_q, s1_ymode_q;

  logic [2:0][SW-1:0]      line_rd;
  logic [3:0][SW-1:0]      newcol;
  logic [2:0][3:0][SW-1:0] win_q;
  logic [3:0][3:0][SW-1:0] hist;

  assign cur    = {depth_infinite_i, depth_value_i};
  assign full_o = s1_valid_q && !s1_fire;
  assign accept = push_i && !full_o;

  always_comb begin
    w_even = SzW'({frame_width_i[CFG_SIZE_W-1:1], 1'b0});
    if (w_even < SzW'(MIN_SIZE)) begin
      w_eff = SzW'(MIN_SIZE);
    end else if (w_even > SzW'(MAX_WIDTH)) begin
      w_eff = SzW'(MAX_WIDTH);
    end else begin
      w_eff = w_even;
    end
    h_even = {frame_height_i[CFG_SIZE_W-1:1], 1'b0};
    if (h_even < HW'(MIN_SIZE)) begin
      h_eff = HW'(MIN_SIZE);
    end else if (h_even > HW'(HEIGHT_LIMIT)) begin
      h_eff = HW'(HEIGHT_LIMIT);
    end else begin
      h_eff = h_even;
    end
  end

  // Cell emission decode for the sample at the current position.
  always_comb begin
    colx     = SzW'(col_q);
    rowx     = HW'(row_q);
    col_last = (colx == w_eff - SzW'(1));
    row_last = (rowx == h_eff - HW'(1));
    col_emit = col_last || (!colx[0] && colx >= SzW'(2) && colx <= w_eff - SzW'(2));
    row_emit = row_last || (!rowx[0] && rowx >= HW'(2) && rowx <= h_eff - HW'(2));
    c0       = col_last ? w_eff - SzW'(2) : colx - SzW'(2);
    r0       = row_last ? h_eff - HW'(2) : rowx - HW'(2);
    xmode    = col_last ? CLAMP_HIGH : ((c0 == '0) ? CLAMP_LOW : CLAMP_NONE);
    ymode    = row_last ? CLAMP_HIGH : ((r0 == '0) ? CLAMP_LOW : CLAMP_NONE);
    col_wrap = (colx + SzW'(1) >= w_eff);
    row_wrap = (rowx + HW'(1) >= h_eff);
    meta_d.cell_x     = c0[CELL_W:1];
    meta_d.cell_y     = r0[CELL_W:1];
    meta_d.frame_last = col_last && row_last;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    mod_d = mod_q;
    if (col_wrap) begin
      col_d = '0;
      if (row_wrap) begin
        row_d = '0;
        mod_d = '0;
      end else begin
        row_d = row_q + ROW_W'(1);
        mod_d = (mod_q == 2'd2) ? 2'd0 : mod_q + 2'd1;
      end
    end else begin
      col_d = col_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      mod_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      mod_q <= mod_d;
    end
  end

  // Three line stores; the one holding the row three above is overwritten.
  for (genvar l = 0; l < 3; l++) begin : g_line
    logic [SW-1:0] mem [MAX_WIDTH];
    logic [SW-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (accept) begin
        rd_q <= mem[col_q];
        if (mod_q == 2'(l)) begin
          mem[col_q] <= cur;
        end
      end
    end

    assign line_rd[l] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_emit_q  <= col_emit && row_emit;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q   <= cur;
      s1_mod_q   <= mod_q;
      s1_meta_q  <= meta_d;
      s1_xmode_q <= xmode;
      s1_ymode_q <= ymode;
    end
  end

  // Order the column from the oldest row to the current sample.
  always_comb begin
    newcol[3] = s1_cur_q;
    unique case (s1_mod_q)
      2'd0: begin
        newcol[0] = line_rd[0];
        newcol[1] = line_rd[1];
        newcol[2] = line_rd[2];
      end
      2'd1: begin
        newcol[0] = line_rd[1];
        newcol[1] = line_rd[2];
        newcol[2] = line_rd[0];
      end
      default: begin
        newcol[0] = line_rd[2];
        newcol[1] = line_rd[0];
        newcol[2] = line_rd[1];
      end
    endcase
  end

  assign s1_fire = s1_valid_q && (!s1_emit_q || !pat_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= newcol;
    end
  end

  always_comb begin
    hist[0] = win_q[0];
    hist[1] = win_q[1];
    hist[2] = win_q[2];
    hist[3] = newcol;
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        patch_o[j][k] = hist[clamp_tap(s1_xmode_q, 2'(k))][clamp_tap(s1_ymode_q, 2'(j))];
      end
    end
  end

  assign pat_push_o = s1_fire && s1_emit_q;
  assign pat_meta_o = s1_meta_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dpcc_back.sv -----
// Back end: second-difference line tests over one 4x4 patch and the surface flag.
`default_nettype none

module dpcc_back #(
  parameter int DEPTH_BITS = dpcc_pkg::DEF_DEPTH_BITS
) (
  input  logic [3:0][3:0][DEPTH_BITS:0]   patch_i,
  input  dpcc_pkg::cell_meta_t            meta_i,
  input  logic [dpcc_pkg::THRESH_W-1:0]   threshold_i,
  output dpcc_pkg::result_t               result_o
);

  import dpcc_pkg::*;

  localparam int SW = DEPTH_BITS + 1;
  localparam int DW = DEPTH_BITS + 3;
  localparam int CW = (DW > THRESH_W) ? DW : THRESH_W;

  // A triple lies on a line if all are infinite, or none is and |a-2b+c| < thr.
  function automatic logic on_line(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                   input logic [SW-1:0] c, input logic [THRESH_W-1:0] thr);
    logic signed [DW-1:0] va, vb, vc, d;
    logic [DW-1:0]        mag;
    logic                 hit;
    va = {{3{a[DEPTH_BITS-1]}}, a[DEPTH_BITS-1:0]};
    vb = {{3{b[DEPTH_BITS-1]}}, b[DEPTH_BITS-1:0]};
    vc = {{3{c[DEPTH_BITS-1]}}, c[DEPTH_BITS-1:0]};
    d   = va - (vb <<< 1) + vc;
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    if (a[SW-1] && b[SW-1] && c[SW-1]) begin
      hit = 1'b1;
    end else if (a[SW-1] || b[SW-1] || c[SW-1]) begin
      hit = 1'b0;
    end else begin
      hit = (CW'(mag) < CW'(thr));
    end
    return hit;
  endfunction

  logic t, r, b, l, tl, tr, bl, br;

  // patch_i[y][x] holds window row y-1 and column x-1 relative to the cell.
  always_comb begin
    t  = on_line(patch_i[3][1], patch_i[2][1], patch_i[1][1], threshold_i) &&
         on_line(patch_i[3][2], patch_i[2][2], patch_i[1][2], threshold_i);
    r  = on_line(patch_i[2][1], patch_i[2][2], patch_i[2][3], threshold_i) &&
         on_line(patch_i[1][1], patch_i[1][2], patch_i[1][3], threshold_i);
    b  = on_line(patch_i[2][1], patch_i[1][1], patch_i[0][1], threshold_i) &&
         on_line(patch_i[2][2], patch_i[1][2], patch_i[0][2], threshold_i);
    l  = on_line(patch_i[2][0], patch_i[2][1], patch_i[2][2], threshold_i) &&
         on_line(patch_i[1][0], patch_i[1][1], patch_i[1][2], threshold_i);
    tl = on_line(patch_i[3][0], patch_i[2][1], patch_i[1][2], threshold_i);
    tr = on_line(patch_i[3][3], patch_i[2][2], patch_i[1][1], threshold_i);
    bl = on_line(patch_i[0][0], patch_i[1][1], patch_i[2][2], threshold_i);
    br = on_line(patch_i[2][1], patch_i[1][2], patch_i[0][3], threshold_i);
  end

  always_comb begin
    result_o.cell_x     = meta_i.cell_x;
    result_o.cell_y     = meta_i.cell_y;
    result_o.surface    = (t && r) || (r && b) || (b && l) || (l && t);
    result_o.continuity = {br, bl, tr, tl, l, b, r, t};
    result_o.frame_last = meta_i.frame_last;
  end

endmodule

`default_nettype wire

// ----- tb/dpcc_scoreboard_pkg.sv -----
// Scoreboard class that predicts and checks the cell results of the continuity classifier.
`timescale 1ns / 100ps

package dpcc_scoreboard_pkg;
  import dpcc_pkg::*;

  localparam int DEPTH_W  = DEF_DEPTH_BITS;
  localparam int LINE_LEN = DEF_MAX_WIDTH;

  typedef struct packed {
    logic                      inf;
    logic signed [DEPTH_W-1:0] val;
  } depth_sample_t;

  class cell_scoreboard;
    depth_sample_t         line_mem[3*LINE_LEN];
    depth_sample_t         window[12];
    int                    col_pos;
    int                    row_pos;
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;
    logic [THRESH_W-1:0]   thresh_reg;
    result_t               pending_cells[$];
    int                    errors;
    int                    cells_seen;
    int                    samples_seen;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (window[i]) window[i] = '0;
      col_pos      = 0;
      row_pos      = 0;
      width_reg    = FRAME_WIDTH_RST;
      height_reg   = FRAME_HEIGHT_RST;
      thresh_reg   = LINE_THRESHOLD_RST;
      errors       = 0;
      cells_seen   = 0;
      samples_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:    width_reg  = data[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT:   height_reg = data[CFG_SIZE_W-1:0];
        REG_LINE_THRESHOLD: thresh_reg = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function int cells_pending();
      return pending_cells.size();
    endfunction

    static function int clamp_size(int raw, int limit);
      int v;
      v = raw & ~1;
      if (v < MIN_SIZE) v = MIN_SIZE;
      if (v > limit) v = limit;
      return v;
    endfunction

    function bit on_line(depth_sample_t a, depth_sample_t b, depth_sample_t c);
      longint d;
      if (a.inf && b.inf && c.inf) return 1'b1;
      if (a.inf || b.inf || c.inf) return 1'b0;
      d = longint'($signed(a.val)) - 2 * longint'($signed(b.val)) + longint'($signed(c.val));
      if (d < 0) d = -d;
      return d < longint'(thresh_reg);
    endfunction

    // Advances the raster position by one sample and queues the cell it completes, if any.
    function void note_sample(depth_sample_t cur);
      int            w, h, col, row, c0, r0, k, j;
      int            xs[4];
      int            ys[4];
      depth_sample_t hist[4][4];
      depth_sample_t p[4][4];
      bit            col_emit, row_emit, t, r, b, l, tl, tr, bl, br;
      result_t       res;

      w   = clamp_size(width_reg, LINE_LEN);
      h   = clamp_size(height_reg, HEIGHT_LIMIT);
      col = col_pos;
      row = row_pos;
      samples_seen++;

      for (j = 0; j < 3; j++) hist[3][j] = '0;
      if (col < LINE_LEN) begin
        hist[3][0] = line_mem[(row % 3) * LINE_LEN + col];
        hist[3][1] = line_mem[((row + 1) % 3) * LINE_LEN + col];
        hist[3][2] = line_mem[((row + 2) % 3) * LINE_LEN + col];
        line_mem[(row % 3) * LINE_LEN + col] = cur;
      end
      hist[3][3] = cur;
      for (k = 0; k < 3; k++)
        for (j = 0; j < 4; j++) hist[k][j] = window[k*4 + j];

      col_emit = (col == w - 1) || ((col % 2) == 0 && col >= 2 && col <= w - 2);
      row_emit = (row == h - 1) || ((row % 2) == 0 && row >= 2 && row <= h - 2);

      if (col_emit && row_emit) begin
        c0 = (col == w - 1) ? w - 2 : col - 2;
        r0 = (row == h - 1) ? h - 2 : row - 2;
        if (col == w - 1) xs = '{1, 2, 3, 3};
        else if (c0 == 0) xs = '{1, 1, 2, 3};
        else              xs = '{0, 1, 2, 3};
        if (row == h - 1) ys = '{1, 2, 3, 3};
        else if (r0 == 0) ys = '{1, 1, 2, 3};
        else              ys = '{0, 1, 2, 3};
        for (j = 0; j < 4; j++)
          for (k = 0; k < 4; k++) p[j][k] = hist[xs[k]][ys[j]];

        // p[y+1][x+1] holds the sample at cell offset (x, y).
        t  = on_line(p[3][1], p[2][1], p[1][1]) && on_line(p[3][2], p[2][2], p[1][2]);
        r  = on_line(p[2][1], p[2][2], p[2][3]) && on_line(p[1][1], p[1][2], p[1][3]);
        b  = on_line(p[2][1], p[1][1], p[0][1]) && on_line(p[2][2], p[1][2], p[0][2]);
        l  = on_line(p[2][0], p[2][1], p[2][2]) && on_line(p[1][0], p[1][1], p[1][2]);
        tl = on_line(p[3][0], p[2][1], p[1][2]);
        tr = on_line(p[3][3], p[2][2], p[1][1]);
        bl = on_line(p[0][0], p[1][1], p[2][2]);
        br = on_line(p[2][1], p[1][2], p[0][3]);

        res.cell_x     = CELL_W'(c0 >> 1);
        res.cell_y     = CELL_W'(r0 >> 1);
        res.surface    = (t && r) || (r && b) || (b && l) || (l && t);
        res.continuity = {br, bl, tr, tl, l, b, r, t};
        res.frame_last = (row == h - 1) && (col == w - 1);
        pending_cells.insert(pending_cells.size(), res);
      end

      for (k = 0; k < 2; k++)
        for (j = 0; j < 4; j++) window[k*4 + j] = window[(k+1)*4 + j];
      for (j = 0; j < 4; j++) window[8 + j] = hist[3][j];

      if (col + 1 >= w) begin
        col_pos = 0;
        row_pos = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col_pos = col + 1;
      end
    endfunction

    function void check_cell(result_t got);
      result_t want;
      if (pending_cells.size() == 0) begin
        $error("cell (%0d,%0d) arrived with no cell expected", got.cell_x, got.cell_y);
        errors++;
        return;
      end
      want = pending_cells.pop_front();
      cells_seen++;
      if (got.cell_x !== want.cell_x) begin
        $error("cell_x: expected %0d, got %0d", want.cell_x, got.cell_x);
        errors++;
      end
      if (got.cell_y !== want.cell_y) begin
        $error("cell_y: expected %0d, got %0d", want.cell_y, got.cell_y);
        errors++;
      end
      if (got.surface !== want.surface) begin
        $error("surface: expected %0b, got %0b", want.surface, got.surface);
        errors++;
      end
      if (got.continuity !== want.continuity) begin
        $error("continuity: expected %08b, got %08b", want.continuity, got.continuity);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_depth_patch_continuity_classifier.sv -----
// Top-level testbench that streams depth frames through the classifier and checks every cell.
`timescale 1ns / 100ps

// The bench streams whole depth frames in raster order and predicts each cell
// with the scoreboard class. It starts with a short hand-made frame that
// covers clamped and odd sizes, an ignored register index, a width change in
// the middle of a row and the extreme depth values. Then it runs one wider
// frame, a tall frame that is cut short by a height change, and a
// series of small frames with random sizes, thresholds and surface content.
// Both handshakes idle at random; some frames run with one side never idle.
module tb_depth_patch_continuity_classifier;
  import dpcc_pkg::*;
  import dpcc_scoreboard_pkg::*;

  // The write index just past the register list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Cycles to let the pipeline empty after the last expected cell.
  localparam int     SETTLE_CYCLES = 8;
  localparam longint CYCLE_LIMIT   = 3_000_000;
  localparam int     RANDOM_TARGET = 600;

  typedef enum {SHAPE_PLANE, SHAPE_NOISE, SHAPE_EXTREME} shape_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      push;
  logic                      full;
  logic signed [DEPTH_W-1:0] depth_value_i;
  logic                      depth_infinite_i;
  logic                      empty;
  logic                      pop;
  logic [CELL_W-1:0]         cell_x_o;
  logic [CELL_W-1:0]         cell_y_o;
  logic                      surface_o;
  logic [CONT_W-1:0]         continuity_o;
  logic                      frame_last_o;

  cell_scoreboard sb;

  // Content of the frame being streamed.
  shape_e shape;
  longint base, grad_x, grad_y;
  int     noise_amp;
  int     hole_mod;
  // When set, that side of the block never idles.
  bit     in_calm, out_calm;
  int     frame_count;
  longint cycle_count;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  depth_patch_continuity_classifier i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .depth_value_i   (depth_value_i),
    .depth_infinite_i(depth_infinite_i),
    .empty           (empty),
    .pop             (pop),
    .cell_x_o        (cell_x_o),
    .cell_y_o        (cell_y_o),
    .surface_o       (surface_o),
    .continuity_o    (continuity_o),
    .frame_last_o    (frame_last_o)
  );

  // Most gaps are short, a few are long, and a calm side never waits.
  function automatic int idle_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic depth_sample_t depth_of(logic inf, int v);
    depth_sample_t s;
    s.inf = inf;
    s.val = DEPTH_W'(v);
    return s;
  endfunction

  // Sample at pixel (x, y) of the current frame content.
  function automatic depth_sample_t surface_sample(int x, int y);
    depth_sample_t s;
    longint        v;
    case (shape)
      SHAPE_NOISE: begin
        s.val = DEPTH_W'($urandom());
        s.inf = 1'($urandom_range(0, 1));
      end
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       s.val = {1'b1, {(DEPTH_W-1){1'b0}}};
          1:       s.val = {1'b0, {(DEPTH_W-1){1'b1}}};
          2:       s.val = '0;
          3:       s.val = '1;
          default: s.val = DEPTH_W'($urandom());
        endcase
        s.inf = ($urandom_range(0, 4) == 0);
      end
      default: begin
        // A tilted plane with bounded noise, wrapping at the field width, with
        // blocks of no-hit samples so that all-infinite triples show up.
        v = base + grad_x * x + grad_y * y
            + longint'($urandom_range(0, 2 * noise_amp)) - noise_amp;
        s.val = DEPTH_W'(v);
        s.inf = (hole_mod != 0 && ((x / 3 + y / 3) % hole_mod) == 0)
                || ($urandom_range(0, 99) < 2);
      end
    endcase
    return s;
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 24'hFFFFFF;
      2:       return int'(LINE_THRESHOLD_RST);
      3, 4, 5: return $urandom_range(1, 4096);
      default: return $urandom_range(0, 24'hFFFFFF);
    endcase
  endfunction

  task automatic pick_content();
    int roll;
    roll      = $urandom_range(0, 9);
    shape     = (roll < 6) ? SHAPE_PLANE : (roll < 8) ? SHAPE_NOISE : SHAPE_EXTREME;
    base      = $urandom_range(0, 24'hFFFFFF);
    grad_x    = longint'($urandom_range(0, 8192)) - 4096;
    grad_y    = longint'($urandom_range(0, 8192)) - 4096;
    noise_amp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2000);
    hole_mod  = $urandom_range(0, 4);
    in_calm   = ($urandom_range(0, 3) == 0);
    out_calm  = ($urandom_range(0, 3) == 0);
  endtask

  // Leaves the write enable high so that back-to-back writes need one
  // assignment per step; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Size writes carry random bits above the 12-bit register to check masking.
  task automatic configure(int w_raw, int h_raw, int thresh, bit poke_unused);
    write_reg(REG_FRAME_WIDTH, {12'($urandom()), 12'(w_raw)});
    write_reg(REG_FRAME_HEIGHT, {12'($urandom()), 12'(h_raw)});
    write_reg(REG_LINE_THRESHOLD, CFG_DATA_W'(thresh));
    if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  // One sample transfer. push stays high across back-to-back transfers.
  task automatic send_sample(depth_sample_t s);
    int gap;
    gap = idle_gap(in_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    depth_value_i    <= s.val;
    depth_infinite_i <= s.inf;
    do @(posedge clk_i); while (full);
    sb.note_sample(s);
  endtask

  task automatic push_rows(int cols, int y0, int rows);
    for (int y = y0; y < y0 + rows; y++)
      for (int x = 0; x < cols; x++) send_sample(surface_sample(x, y));
  endtask

  // Waits until every predicted cell has been popped and the pipeline is quiet.
  task automatic settle();
    push <= 1'b0;
    while (sb.cells_pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic collect_cells();
    int      gap;
    result_t got;
    forever begin
      gap = idle_gap(out_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.cell_x     = cell_x_o;
      got.cell_y     = cell_y_o;
      got.surface    = surface_o;
      got.continuity = continuity_o;
      got.frame_last = frame_last_o;
      sb.check_cell(got);
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int random_start;
    int w_eff, h_eff, w_raw, h_raw;

    sb               = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    push             = 1'b0;
    depth_value_i    = '0;
    depth_infinite_i = 1'b0;
    pop              = 1'b0;
    in_calm          = 1'b0;
    out_calm         = 1'b0;
    frame_count      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      collect_cells();
    join_none

    // Hand-made frame. The width starts above the line limit and the height
    // below the minimum, and a write to the unused index must change nothing.
    configure(4095, 2, int'(LINE_THRESHOLD_RST), 1'b1);
    for (int x = 0; x < 4; x++) send_sample(depth_of(1'b1, 0));
    send_sample(depth_of(1'b0, -8388608));
    send_sample(depth_of(1'b0, 8388607));
    // Narrow to an odd width in the middle of row 0: the next sample is past
    // the new edge, so it ends the row without producing a cell.
    settle();
    configure(5, 2, int'(LINE_THRESHOLD_RST), 1'b0);
    send_sample(depth_of(1'b0, -1));
    // Row 1 holds the depth extremes, row 2 mixes finite and infinite samples,
    // row 3 is flat so that finite triples are on a line.
    send_sample(depth_of(1'b0, -8388608));
    send_sample(depth_of(1'b0, 8388607));
    send_sample(depth_of(1'b0, 0));
    send_sample(depth_of(1'b0, -1));
    send_sample(depth_of(1'b0, 100));
    send_sample(depth_of(1'b1, 0));
    send_sample(depth_of(1'b0, 100));
    send_sample(depth_of(1'b0, 300));
    for (int x = 0; x < 4; x++) send_sample(depth_of(1'b0, 7));
    frame_count++;
    settle();

    // One wider frame, four rows deep.
    pick_content();
    w_raw = $urandom_range(48, 96);
    w_eff = cell_scoreboard::clamp_size(w_raw, LINE_LEN);
    configure(w_raw, $urandom_range(4, 5), pick_threshold(), 1'b0);
    push_rows(w_eff, 0, 4);
    frame_count++;
    settle();

    // A frame at the height limit, cut short after ten rows by a height
    // change; row ten then ends the frame.
    pick_content();
    configure(4, $urandom_range(2048, 4095), pick_threshold(), 1'b0);
    push_rows(4, 0, 10);
    settle();
    configure(4, 4, int'(sb.thresh_reg), 1'b1);
    push_rows(4, 10, 1);
    frame_count++;
    settle();

    // Small frames with random sizes, including raw sizes below the minimum
    // and odd ones. The first two use the threshold extremes.
    random_start = sb.samples_seen;
    while (sb.samples_seen - random_start < RANDOM_TARGET) begin
      pick_content();
      w_raw = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
      h_raw = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
      w_eff = cell_scoreboard::clamp_size(w_raw, LINE_LEN);
      h_eff = cell_scoreboard::clamp_size(h_raw, HEIGHT_LIMIT);
      configure(w_raw, h_raw,
                (frame_count == 3) ? 0 : (frame_count == 4) ? 24'hFFFFFF : pick_threshold(),
                $urandom_range(0, 7) == 0);
      push_rows(w_eff, 0, h_eff);
      frame_count++;
      settle();
    end

    $display("Streamed %0d depth samples in %0d frames and checked %0d cells.",
             sb.samples_seen, frame_count, sb.cells_seen);
    $display("Frames covered clamped and odd sizes, the height limit and mid-frame size changes.");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
